// ===== rtl/core/base64_byte_stream_encoder_defines.svh =====
// Assertion macros shared by the encoder's RTL files.
// Each macro samples on the rising edge of clk and is disabled during rst.
`ifndef BASE64_BYTE_STREAM_ENCODER_DEFINES_SVH
`define BASE64_BYTE_STREAM_ENCODER_DEFINES_SVH

// Same-cycle implication.
`define B64_ASSERT_IMPLIES(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication check failed");

// Next-cycle implication.
`define B64_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// ===== rtl/core/b64enc_pkg.sv =====
package b64enc_pkg;

  // Default depth of the queue between the front and the back end.
  localparam int QUEUE_DEPTH = 4;

  // Position within the current three-byte group.
  typedef enum logic [1:0] {
    PH_ZERO = 2'd0,
    PH_ONE  = 2'd1,
    PH_TWO  = 2'd2
  } group_phase_t;

  // One classified byte: one or two sextets to emit.
  typedef struct packed {
    logic [5:0] first_sextet;
    logic [5:0] second_sextet;
    logic       two_chars;
    logic       last;
  } group_entry_t;

  localparam logic [6:0] ASCII_UPPER_A = 7'd65;
  localparam logic [6:0] ASCII_LOWER_A = 7'd97;
  localparam logic [6:0] ASCII_ZERO    = 7'd48;
  localparam logic [6:0] ASCII_PLUS    = 7'd43;
  localparam logic [6:0] ASCII_SLASH   = 7'd47;

  // Standard base64 alphabet lookup.
  function automatic logic [6:0] sextet_to_ascii(input logic [5:0] v);
    logic [6:0] result;
    if (v < 6'd26) begin
      result = ASCII_UPPER_A + {1'b0, v};
    end else if (v < 6'd52) begin
      result = ASCII_LOWER_A + {1'b0, v} - 7'd26;
    end else if (v < 6'd62) begin
      result = ASCII_ZERO + {1'b0, v} - 7'd52;
    end else if (v == 6'd62) begin
      result = ASCII_PLUS;
    end else begin
      result = ASCII_SLASH;
    end
    return result;
  endfunction

endpackage

// ===== rtl/core/b64enc_front.sv =====
module b64enc_front (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     accept,
  input  logic [7:0]               data_byte,
  input  logic                     final_byte,
  output b64enc_pkg::group_entry_t entry
);
  import b64enc_pkg::*;

  group_phase_t group_phase, group_phase_next;
  logic [3:0]   carry_bits, carry_bits_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      group_phase <= PH_ZERO;
      carry_bits  <= 4'd0;
    end else if (accept) begin
      group_phase <= group_phase_next;
      carry_bits  <= carry_bits_next;
    end
  end

  // Next state of the group tracker. A final byte always restarts the group.
  always_comb begin
    unique case (group_phase)
      PH_ONE: begin
        group_phase_next = PH_TWO;
        carry_bits_next  = data_byte[3:0];
      end
      PH_TWO: begin
        group_phase_next = PH_ZERO;
        carry_bits_next  = 4'd0;
      end
      default: begin
        group_phase_next = PH_ONE;
        carry_bits_next  = {2'b00, data_byte[1:0]};
      end
    endcase
    if (final_byte) begin
      group_phase_next = PH_ZERO;
      carry_bits_next  = 4'd0;
    end
  end

  // Sextets for this byte; a final byte in a partial group adds a zero-filled flush.
  always_comb begin
    entry.last = final_byte;
    unique case (group_phase)
      PH_ONE: begin
        entry.first_sextet  = {carry_bits[1:0], data_byte[7:4]};
        entry.second_sextet = {data_byte[3:0], 2'b00};
        entry.two_chars     = final_byte;
      end
      PH_TWO: begin
        entry.first_sextet  = {carry_bits, data_byte[7:6]};
        entry.second_sextet = data_byte[5:0];
        entry.two_chars     = 1'b1;
      end
      default: begin
        entry.first_sextet  = data_byte[7:2];
        entry.second_sextet = {data_byte[1:0], 4'b0000};
        entry.two_chars     = final_byte;
      end
    endcase
  end

endmodule

// ===== rtl/core/b64enc_fifo.sv =====
`include "base64_byte_stream_encoder_defines.svh"

module b64enc_fifo #(
  parameter int Depth = b64enc_pkg::QUEUE_DEPTH
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     wr_en,
  input  b64enc_pkg::group_entry_t wr_data,
  output logic                     full,
  input  logic                     rd_en,
  output b64enc_pkg::group_entry_t rd_data,
  output logic                     empty
);
  import b64enc_pkg::*;

  localparam int PtrWidth   = $clog2(Depth);
  localparam int CountWidth = $clog2(Depth + 1);

  group_entry_t          slots [Depth];
  logic [PtrWidth-1:0]   wr_ptr, rd_ptr;
  logic [CountWidth-1:0] count;
  logic                  do_wr, do_rd;

  assign full  = (count == CountWidth'(Depth));
  assign empty = (count == '0);
  assign do_wr = wr_en && !full;
  assign do_rd = rd_en && !empty;
  assign rd_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PtrWidth'(Depth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PtrWidth'(Depth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

  `B64_ASSERT_IMPLIES(a_count_bounded, 1'b1, count <= CountWidth'(Depth))
  `B64_ASSERT_NEXT(a_fill_grows, do_wr && !do_rd, !empty)
  `B64_ASSERT_IMPLIES(a_ptrs_match_count, empty || full, wr_ptr == rd_ptr)

endmodule

// ===== rtl/core/b64enc_back.sv =====
`include "base64_byte_stream_encoder_defines.svh"

module b64enc_back (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     q_empty,
  input  b64enc_pkg::group_entry_t q_data,
  output logic                     q_rd,
  output logic                     empty,
  input  logic                     pop,
  output logic [6:0]               out_char,
  output logic                     out_last
);
  import b64enc_pkg::*;

  group_entry_t cur_entry;
  logic         cur_valid;
  logic         cur_second;
  logic         finishing;
  logic         load;

  // The held entry is done when its last character is taken.
  assign finishing = pop && cur_valid && (cur_second || !cur_entry.two_chars);
  assign load      = !q_empty && (!cur_valid || finishing);
  assign q_rd      = load;

  always_ff @(posedge clk) begin
    if (load) begin
      cur_entry <= q_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid  <= 1'b0;
      cur_second <= 1'b0;
    end else if (load) begin
      cur_valid  <= 1'b1;
      cur_second <= 1'b0;
    end else if (finishing) begin
      cur_valid  <= 1'b0;
      cur_second <= 1'b0;
    end else if (pop && cur_valid) begin
      cur_second <= 1'b1;
    end
  end

  assign empty    = !cur_valid;
  assign out_char = sextet_to_ascii(cur_second ? cur_entry.second_sextet
                                               : cur_entry.first_sextet);
  assign out_last = cur_entry.last && cur_second;

  `B64_ASSERT_IMPLIES(a_second_needs_pair, cur_valid && cur_second, cur_entry.two_chars)
  `B64_ASSERT_NEXT(a_first_then_second, pop && cur_valid && !finishing,
                   cur_valid && cur_second)
  `B64_ASSERT_IMPLIES(a_load_only_when_free, load, !cur_valid || finishing)

endmodule

// ===== rtl/core/base64_byte_stream_encoder.sv =====
// An accepted byte is written into the queue, then loaded into the back end's held
// entry register, from which its first character can be popped.
// Throughput: one byte per cycle into the queue while it is not full; the back end
// emits one character per cycle while pop is high and it holds an entry. A full group
// of three bytes yields four characters, all through the single character port.
// Reset (rst, synchronous, active high) restarts the group at a triple boundary and
// empties the queue and the output stage.
module base64_byte_stream_encoder #(
  parameter int QueueDepth = b64enc_pkg::QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [7:0] data_byte,
  input  logic       final_byte,
  output logic       empty,
  input  logic       pop,
  output logic [6:0] out_char,
  output logic       out_last
);
  import b64enc_pkg::*;

  // The front end keeps the group phase and leftover bits, and turns each accepted
  // word into one queue entry carrying one or two sextets plus the last flag.
  group_entry_t front_entry;
  group_entry_t q_data;
  logic         accept;
  logic         q_empty;
  logic         q_rd;

  // A word is taken whenever the queue has room; the queue's full flag is the
  // only backpressure the sender sees.
  assign accept = push && !full;

  b64enc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .data_byte  (data_byte),
    .final_byte (final_byte),
    .entry      (front_entry)
  );

  // The queue decouples byte intake from character output, so a stalled reader
  // does not stop bytes from arriving until the queue fills.
  b64enc_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (accept),
    .wr_data (front_entry),
    .full    (full),
    .rd_en   (q_rd),
    .rd_data (q_data),
    .empty   (q_empty)
  );

  // The back end holds one entry and serializes its sextets through the
  // alphabet table, one character per word on the output side.
  b64enc_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_empty  (q_empty),
    .q_data   (q_data),
    .q_rd     (q_rd),
    .empty    (empty),
    .pop      (pop),
    .out_char (out_char),
    .out_last (out_last)
  );

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import b64enc_pkg::*;

  // One byte of a message as the sender will offer it, with the number of idle
  // cycles the sender waits before it raises push for this byte.
  typedef struct {
    logic [7:0] data;
    logic       fin;
    int         gap;
  } msg_byte_t;

  // One character that the encoder is expected to emit.
  typedef struct {
    logic [6:0] ch;
    logic       last;
  } b64_char_t;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 8;
  // The receiver stops draining after this many characters, for a stretch long
  // enough that the encoder's internal queue fills and full is raised.
  localparam int HOLD_AT        = 300;
  localparam int HOLD_CYCLES    = 120;
  localparam int RANDOM_BYTES   = 1030;

  // Standard alphabet, packed one ASCII code per byte, index 0 in the top byte.
  localparam logic [8*64-1:0] ALPHABET =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       push = 1'b0;
  logic       full;
  logic [7:0] data_byte = 8'h00;
  logic       final_byte = 1'b0;
  logic       empty;
  logic       pop = 1'b0;
  logic [6:0] out_char;
  logic       out_last;

  always #4 clk = ~clk;

  base64_byte_stream_encoder DUT (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .data_byte  (data_byte),
    .final_byte (final_byte),
    .empty      (empty),
    .pop        (pop),
    .out_char   (out_char),
    .out_last   (out_last)
  );

  msg_byte_t pending_bytes[$];
  b64_char_t expected_chars[$];

  // Shadow copy of the encoder's group state, advanced once per accepted word.
  group_phase_t enc_phase = PH_ZERO;
  logic [3:0]   enc_carry = 4'h0;

  int error_count     = 0;
  int bytes_accepted  = 0;
  int messages_closed = 0;
  int chars_checked   = 0;
  int full_stalls     = 0;
  int idle_cycles     = 0;
  int tx_wait         = 0;
  int rx_wait         = 0;
  int rx_draw;
  bit rx_calm         = 1'b0;

  task automatic report_mismatch(input string what);
    if (error_count < 40) begin
      $display("[%0t] mismatch: %s", $time, what);
    end
    error_count++;
  endtask

  function automatic logic [6:0] sextet_ascii(input logic [5:0] v);
    logic [7:0] code;
    code = ALPHABET[8*(63 - v) +: 8];
    return code[6:0];
  endfunction

  // Works out the characters one accepted byte produces and queues them in
  // order. Every final byte yields two characters: at phase 2 the group is
  // complete anyway, and at phase 0 or 1 the leftover bits are flushed with
  // zero fill. Only the second character of a final byte carries the last flag.
  function automatic void encode_byte(input logic [7:0] b, input logic fin);
    logic [5:0] first_sx;
    logic [5:0] second_sx;
    bit         two;
    b64_char_t  c;
    case (enc_phase)
      PH_ONE: begin
        first_sx  = {enc_carry[1:0], b[7:4]};
        second_sx = {b[3:0], 2'b00};
        two       = fin;
        enc_carry = b[3:0];
        enc_phase = PH_TWO;
      end
      PH_TWO: begin
        first_sx  = {enc_carry, b[7:6]};
        second_sx = b[5:0];
        two       = 1'b1;
        enc_carry = 4'h0;
        enc_phase = PH_ZERO;
      end
      default: begin
        // The unused phase encoding behaves like the start of a group.
        first_sx  = b[7:2];
        second_sx = {b[1:0], 4'b0000};
        two       = fin;
        enc_carry = {2'b00, b[1:0]};
        enc_phase = PH_ONE;
      end
    endcase
    if (fin) begin
      enc_phase = PH_ZERO;
      enc_carry = 4'h0;
    end
    c.ch   = sextet_ascii(first_sx);
    c.last = 1'b0;
    expected_chars.push_back(c);
    if (two) begin
      c.ch   = sextet_ascii(second_sx);
      c.last = fin;
      expected_chars.push_back(c);
    end
  endfunction

  // Appends one message to the stimulus. With calm set the sender offers its
  // bytes back to back; otherwise every byte draws its gap at random.
  task automatic queue_message(input logic [7:0] bytes[$], input bit calm,
                               input bit closed);
    msg_byte_t m;
    foreach (bytes[i]) begin
      m.data = bytes[i];
      m.fin  = closed && (i == bytes.size() - 1);
      m.gap  = calm ? 0 : $urandom_range(0, 5);
      pending_bytes.push_back(m);
    end
  endtask

  // Sender. A word is taken at an edge where push is high and full is low; the
  // expectation is formed right there, long before its characters can appear.
  always @(posedge clk) begin
    if (rst) begin
      push    <= 1'b0;
      tx_wait <= 0;
    end else if (push && !full) begin
      encode_byte(data_byte, final_byte);
      bytes_accepted++;
      if (final_byte) begin
        messages_closed++;
      end
      if (pending_bytes.size() != 0 && pending_bytes[0].gap == 0) begin
        // Keep push high and move straight on to the next byte.
        data_byte  <= pending_bytes[0].data;
        final_byte <= pending_bytes[0].fin;
        void'(pending_bytes.pop_front());
      end else begin
        push <= 1'b0;
        if (pending_bytes.size() != 0) begin
          tx_wait <= pending_bytes[0].gap - 1;
        end
      end
    end else if (!push && pending_bytes.size() != 0) begin
      if (tx_wait > 0) begin
        tx_wait <= tx_wait - 1;
      end else begin
        data_byte  <= pending_bytes[0].data;
        final_byte <= pending_bytes[0].fin;
        push       <= 1'b1;
        void'(pending_bytes.pop_front());
      end
    end
  end

  // Receiver and checker. Each popped character is compared field by field
  // with the oldest expectation.
  always @(posedge clk) begin
    if (rst) begin
      pop     <= 1'b0;
      rx_wait <= 0;
    end else if (pop && !empty) begin
      if (expected_chars.size() == 0) begin
        report_mismatch($sformatf("character 0x%02h arrived with nothing expected",
                                  out_char));
      end else begin
        if (out_char !== expected_chars[0].ch) begin
          report_mismatch($sformatf("character %0d: out_char 0x%02h, expected 0x%02h",
                                    chars_checked, out_char, expected_chars[0].ch));
        end
        if (out_last !== expected_chars[0].last) begin
          report_mismatch($sformatf("character %0d: out_last %0b, expected %0b",
                                    chars_checked, out_last, expected_chars[0].last));
        end
        void'(expected_chars.pop_front());
      end
      chars_checked++;
      // Every fifty characters the receiver decides whether to drain at full
      // rate for a while or to idle at random.
      if (chars_checked % 50 == 0) begin
        rx_calm = ($urandom_range(0, 2) == 0);
      end
      rx_draw = rx_calm ? 0 : $urandom_range(0, 5);
      if (chars_checked == HOLD_AT) begin
        pop     <= 1'b0;
        rx_wait <= HOLD_CYCLES;
      end else if (rx_draw != 0) begin
        pop     <= 1'b0;
        rx_wait <= rx_draw - 1;
      end
    end else if (!pop) begin
      if (rx_wait > 0) begin
        rx_wait <= rx_wait - 1;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // Watchdog: a run in which no word moves on either side for too long is hung.
  always @(posedge clk) begin
    if (!rst) begin
      if (push && full) begin
        full_stalls++;
      end
      if ((push && !full) || (pop && !empty)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("timeout: no word moved for %0d cycles", WATCHDOG_LIMIT);
        $display("FAIL base64_byte_stream_encoder");
        $finish;
      end
    end
  end

  initial begin
    logic [7:0] msg[$];
    int         len;
    int         total;

    // Directed messages. A single byte ends at phase 0, two bytes end at
    // phase 1, three bytes close a full group, and four bytes end at phase 0
    // after a full group. The all-ones and 0xFB bytes reach '/' and '+',
    // the all-zeros byte reaches 'A'.
    msg = {8'h00};                   queue_message(msg, 1'b1, 1'b1);
    msg = {8'hFF};                   queue_message(msg, 1'b0, 1'b1);
    msg = {8'hFF, 8'h00};            queue_message(msg, 1'b1, 1'b1);
    msg = {8'h00, 8'hFF};            queue_message(msg, 1'b0, 1'b1);
    msg = {8'hFB, 8'hEF, 8'hBE};     queue_message(msg, 1'b1, 1'b1);
    msg = {8'hFF, 8'hFF, 8'hFF};     queue_message(msg, 1'b0, 1'b1);
    msg = {8'h80, 8'h01, 8'h7F};     queue_message(msg, 1'b0, 1'b1);
    msg = {8'h4D, 8'h61, 8'h6E, 8'h12}; queue_message(msg, 1'b1, 1'b1);
    msg = {8'h55, 8'hAA};            queue_message(msg, 1'b0, 1'b1);

    // Random messages: mostly short ones so that every phase meets the final
    // flag often, a few long ones, and now and then a run of bytes whose
    // final flags fall at random.
    total = 0;
    while (total < RANDOM_BYTES) begin
      msg.delete();
      if ($urandom_range(0, 9) < 8) begin
        len = $urandom_range(1, 12);
      end else begin
        len = $urandom_range(13, 40);
      end
      repeat (len) msg.push_back(8'($urandom_range(0, 255)));
      if ($urandom_range(0, 9) == 0) begin
        foreach (msg[i]) begin
          msg_byte_t m;
          m.data = msg[i];
          m.fin  = 1'($urandom_range(0, 1));
          m.gap  = $urandom_range(0, 5);
          pending_bytes.push_back(m);
        end
      end else begin
        queue_message(msg, ($urandom_range(0, 2) == 0), 1'b1);
      end
      total += len;
    end

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Wait for every byte to be taken and every character to come out, then
    // keep watching for anything the encoder should not have sent.
    while (pending_bytes.size() != 0 || push || expected_chars.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_chars.size() != 0) begin
      report_mismatch($sformatf("%0d characters never arrived", expected_chars.size()));
    end

    $display("Encoded %0d bytes in %0d closed messages; %0d characters checked.",
             bytes_accepted, messages_closed, chars_checked);
    $display("Input stalled on full for %0d cycles; %0d mismatches.",
             full_stalls, error_count);
    if (error_count == 0) begin
      $display("PASS base64_byte_stream_encoder");
    end else begin
      $display("FAIL base64_byte_stream_encoder");
    end
    $finish;
  end

endmodule
